### sv/rdi_pkg.sv
// ----------------------------------------------------------------------------
// rdi_pkg
// Shared widths and constants of the ray / disk intersection pipeline.
// ----------------------------------------------------------------------------
package rdi_pkg;

    localparam int DATA_W         = 32;
    localparam int RAD_W          = 31;
    localparam int DIST_W         = 31;
    localparam int THR_W          = 16;
    localparam int PROD_W         = 2 * DATA_W;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic [THR_W-1:0]  THR_RESET = 16'd66;
    localparam logic [DIST_W-1:0] T_MAX     = 31'h7FFF_FFFF;

endpackage

### sv/rdi_if.sv
// ----------------------------------------------------------------------------
// rdi interfaces
// Request, result and threshold-write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rdi_req_if;
    logic                             valid;
    logic                             ready;
    logic signed [rdi_pkg::DATA_W-1:0] dir_x;
    logic signed [rdi_pkg::DATA_W-1:0] dir_y;
    logic signed [rdi_pkg::DATA_W-1:0] dir_z;
    logic signed [rdi_pkg::DATA_W-1:0] offset_x;
    logic signed [rdi_pkg::DATA_W-1:0] offset_y;
    logic signed [rdi_pkg::DATA_W-1:0] offset_z;
    logic signed [rdi_pkg::DATA_W-1:0] normal_x;
    logic signed [rdi_pkg::DATA_W-1:0] normal_y;
    logic signed [rdi_pkg::DATA_W-1:0] normal_z;
    logic        [rdi_pkg::RAD_W-1:0]  disk_radius;

    modport source (output valid, dir_x, dir_y, dir_z, offset_x, offset_y, offset_z,
                    normal_x, normal_y, normal_z, disk_radius, input ready);
    modport sink   (input valid, dir_x, dir_y, dir_z, offset_x, offset_y, offset_z,
                    normal_x, normal_y, normal_z, disk_radius, output ready);
endinterface

interface rdi_res_if;
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic [rdi_pkg::DIST_W-1:0]  distance;

    modport source (output valid, hit, distance, input ready);
    modport sink   (input valid, hit, distance, output ready);
endinterface

interface rdi_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [rdi_pkg::THR_W-1:0]   near_threshold;

    modport source (output valid, near_threshold, input ready);
    modport sink   (input valid, near_threshold, output ready);
endinterface

### sv/rdi_div.sv
// ----------------------------------------------------------------------------
// rdi_div
// Pipelined restoring divider, one quotient bit per stage, with overflow
// detect for quotients that do not fit the distance width.
// ----------------------------------------------------------------------------
module rdi_div #(
    parameter int FRAC_BITS = rdi_pkg::FRAC_BITS_DEF,
    parameter int SIDE_W    = 1
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_en,
    input  logic                                          i_vld,
    input  logic [2*rdi_pkg::DATA_W+1-FRAC_BITS:0]        i_mag_n,
    input  logic [2*rdi_pkg::DATA_W+1-FRAC_BITS:0]        i_mag_d,
    input  logic [SIDE_W-1:0]                             i_side,
    output logic                                          o_vld,
    output logic                                          o_ovf,
    output logic [rdi_pkg::DIST_W-1:0]                    o_quot,
    output logic [SIDE_W-1:0]                             o_side
);
    import rdi_pkg::*;

    localparam int MW = 2*DATA_W + 2 - FRAC_BITS;
    localparam int NW = MW + FRAC_BITS;
    localparam int QB = DIST_W;
    localparam int CW = MW + QB;

    logic              r_vld  [0:QB];
    logic [MW-1:0]     r_rem  [0:QB];
    logic [QB-1:0]     r_lo   [0:QB];
    logic [MW-1:0]     r_den  [0:QB];
    logic              r_ovf  [0:QB];
    logic [QB-1:0]     r_q    [0:QB];
    logic [SIDE_W-1:0] r_side [0:QB];

    logic [NW-1:0] num;
    assign num = {i_mag_n, {FRAC_BITS{1'b0}}};

    // first stage: overflow test and top bits of the dividend
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= MW'(num >> QB);
            r_lo[0]   <= num[QB-1:0];
            r_den[0]  <= i_mag_d;
            r_ovf[0]  <= CW'(num) >= {i_mag_d, {QB{1'b0}}};
            r_q[0]    <= '0;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_step
        logic [MW:0] trial;
        logic        ge;
        assign trial = {r_rem[k-1], r_lo[k-1][QB-k]};
        assign ge    = trial >= {1'b0, r_den[k-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? MW'(trial - {1'b0, r_den[k-1]}) : MW'(trial);
                r_lo[k]   <= r_lo[k-1];
                r_den[k]  <= r_den[k-1];
                r_ovf[k]  <= r_ovf[k-1];
                r_q[k]    <= {r_q[k-1][QB-2:0], ge};
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_vld  = r_vld[QB];
    assign o_ovf  = r_ovf[QB];
    assign o_quot = r_q[QB];
    assign o_side = r_side[QB];

endmodule

### sv/ray_disk_intersection.sv
// ----------------------------------------------------------------------------
// ray_disk_intersection
// Fixed-point ray against disk test, fully pipelined, one request per cycle.
// ----------------------------------------------------------------------------
//  channel   dir  content
//  i_req     in   direction, offset, normal, radius
//  o_res     out  hit flag and distance
//  i_cfg     in   near_threshold write
//
//  one request per cycle while results are taken; the divider has an
//  overflow stage, then one quotient bit per stage
//  a stalled result holds the whole pipeline; nothing is lost or repeated
//  reset clears all valid bits and loads near_threshold with 66
module ray_disk_intersection
#(
    parameter int FRAC_BITS = rdi_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rdi_req_if.sink     i_req,
    rdi_res_if.source   o_res,
    rdi_cfg_if.sink     i_cfg
);
    import rdi_pkg::*;

    localparam int DW     = 2*DATA_W + 2 - FRAC_BITS;
    localparam int SIDE_W = 1 + RAD_W + 6*DATA_W;

    logic en;
    assign en          = !o_res.valid || o_res.ready;
    assign i_req.ready = en;
    assign i_cfg.ready = 1'b1;

    logic [THR_W-1:0] r_thr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg.valid) begin
            r_thr <= i_cfg.near_threshold;
        end
    end

    // stage 1: dot product terms
    logic                     r1_vld;
    logic signed [PROD_W-1:0] r1_pd [3];
    logic signed [PROD_W-1:0] r1_pn [3];
    logic signed [DATA_W-1:0] r1_dir [3];
    logic signed [DATA_W-1:0] r1_off [3];
    logic [RAD_W-1:0]         r1_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_pd[0]  <= i_req.normal_x * i_req.dir_x;
            r1_pd[1]  <= i_req.normal_y * i_req.dir_y;
            r1_pd[2]  <= i_req.normal_z * i_req.dir_z;
            r1_pn[0]  <= i_req.offset_x * i_req.normal_x;
            r1_pn[1]  <= i_req.offset_y * i_req.normal_y;
            r1_pn[2]  <= i_req.offset_z * i_req.normal_z;
            r1_dir[0] <= i_req.dir_x;
            r1_dir[1] <= i_req.dir_y;
            r1_dir[2] <= i_req.dir_z;
            r1_off[0] <= i_req.offset_x;
            r1_off[1] <= i_req.offset_y;
            r1_off[2] <= i_req.offset_z;
            r1_rad    <= i_req.disk_radius;
        end
    end

    // stage 2: floor-shifted sums
    logic                     r2_vld;
    logic signed [DW-1:0]     r2_d;
    logic signed [DW-1:0]     r2_n;
    logic signed [DATA_W-1:0] r2_dir [3];
    logic signed [DATA_W-1:0] r2_off [3];
    logic [RAD_W-1:0]         r2_rad;
    logic signed [DW-1:0]     n2_d;
    logic signed [DW-1:0]     n2_n;

    always_comb begin
        n2_d = DW'(r1_pd[0] >>> FRAC_BITS) + DW'(r1_pd[1] >>> FRAC_BITS)
             + DW'(r1_pd[2] >>> FRAC_BITS);
        n2_n = DW'(r1_pn[0] >>> FRAC_BITS) + DW'(r1_pn[1] >>> FRAC_BITS)
             + DW'(r1_pn[2] >>> FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_d   <= n2_d;
            r2_n   <= n2_n;
            r2_dir <= r1_dir;
            r2_off <= r1_off;
            r2_rad <= r1_rad;
        end
    end

    // stage 3: magnitudes, parallel and wrong-side tests
    logic                     r3_vld;
    logic [DW-1:0]            r3_mag_d;
    logic [DW-1:0]            r3_mag_n;
    logic                     r3_miss;
    logic signed [DATA_W-1:0] r3_dir [3];
    logic signed [DATA_W-1:0] r3_off [3];
    logic [RAD_W-1:0]         r3_rad;
    logic [DW-1:0]            n3_mag_d;
    logic [DW-1:0]            n3_mag_n;
    logic                     n3_miss;

    always_comb begin
        n3_mag_d = r2_d[DW-1] ? DW'(-r2_d) : DW'(r2_d);
        n3_mag_n = r2_n[DW-1] ? DW'(-r2_n) : DW'(r2_n);
        n3_miss  = (n3_mag_d <= DW'(r_thr))
                || ((r2_n != '0) && (r2_n[DW-1] != r2_d[DW-1]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_mag_d <= n3_mag_d;
            r3_mag_n <= n3_mag_n;
            r3_miss  <= n3_miss;
            r3_dir   <= r2_dir;
            r3_off   <= r2_off;
            r3_rad   <= r2_rad;
        end
    end

    // divider
    logic              dv_vld;
    logic              dv_ovf;
    logic [DIST_W-1:0] dv_quot;
    logic [SIDE_W-1:0] dv_side;

    rdi_div #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SIDE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r3_vld),
        .i_mag_n (r3_mag_n),
        .i_mag_d (r3_mag_d),
        .i_side  ({r3_miss, r3_rad, r3_off[2], r3_off[1], r3_off[0],
                   r3_dir[2], r3_dir[1], r3_dir[0]}),
        .o_vld   (dv_vld),
        .o_ovf   (dv_ovf),
        .o_quot  (dv_quot),
        .o_side  (dv_side)
    );

    logic signed [DATA_W-1:0] dv_dir [3];
    logic signed [DATA_W-1:0] dv_off [3];
    logic [RAD_W-1:0]         dv_rad;
    logic                     dv_miss;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dv_dir[i] = dv_side[i*DATA_W +: DATA_W];
            dv_off[i] = dv_side[(3+i)*DATA_W +: DATA_W];
        end
        dv_rad  = dv_side[6*DATA_W +: RAD_W];
        dv_miss = dv_side[SIDE_W-1];
    end

    // stage 4: saturate t, minimum distance, hit point products
    logic                     r4_vld;
    logic [DIST_W-1:0]        r4_t;
    logic                     r4_miss;
    logic signed [PROD_W-1:0] r4_ph [3];
    logic signed [DATA_W-1:0] r4_off [3];
    logic [RAD_W-1:0]         r4_rad;
    logic [DIST_W-1:0]        n4_t;

    assign n4_t = dv_ovf ? T_MAX : dv_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_t    <= n4_t;
            r4_miss <= dv_miss || (n4_t < DIST_W'(r_thr));
            for (int i = 0; i < 3; i++) begin
                r4_ph[i] <= dv_dir[i] * $signed({1'b0, n4_t});
            end
            r4_off <= dv_off;
            r4_rad <= dv_rad;
        end
    end

    // stage 5: hit point components and per-axis radius test
    logic               r5_vld;
    logic [DIST_W-1:0]  r5_t;
    logic               r5_miss;
    logic [RAD_W-1:0]   r5_a [3];
    logic [RAD_W-1:0]   r5_rad;
    logic [PROD_W-1:0]  n5_a [3];
    logic               n5_out;

    always_comb begin
        logic signed [PROD_W-1:0] v;
        n5_out = 1'b0;
        for (int i = 0; i < 3; i++) begin
            v       = (r4_ph[i] >>> FRAC_BITS) - PROD_W'(r4_off[i]);
            n5_a[i] = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
            n5_out  = n5_out || (n5_a[i] > PROD_W'(r4_rad));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (en) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_t    <= r4_t;
            r5_miss <= r4_miss || n5_out;
            for (int i = 0; i < 3; i++) begin
                r5_a[i] <= n5_a[i][RAD_W-1:0];
            end
            r5_rad <= r4_rad;
        end
    end

    // stage 6: squares
    logic                 r6_vld;
    logic [DIST_W-1:0]    r6_t;
    logic                 r6_miss;
    logic [2*RAD_W-1:0]   r6_sq [3];
    logic [2*RAD_W-1:0]   r6_rr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (en) begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_t    <= r5_t;
            r6_miss <= r5_miss;
            for (int i = 0; i < 3; i++) begin
                r6_sq[i] <= r5_a[i] * r5_a[i];
            end
            r6_rr <= r5_rad * r5_rad;
        end
    end

    // stage 7: radius test on the sum of squares, output register
    logic              r7_vld;
    logic              r7_hit;
    logic [DIST_W-1:0] r7_dist;
    logic [PROD_W-1:0] n7_sum;
    logic              n7_hit;

    always_comb begin
        n7_sum = PROD_W'(r6_sq[0]) + PROD_W'(r6_sq[1]) + PROD_W'(r6_sq[2]);
        n7_hit = !r6_miss && (n7_sum <= PROD_W'(r6_rr));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (en) begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_hit  <= n7_hit;
            r7_dist <= n7_hit ? r6_t : '0;
        end
    end

    assign o_res.valid    = r7_vld;
    assign o_res.hit      = r7_hit;
    assign o_res.distance = r7_dist;

endmodule
